// ----- sv/kscl_pkg.sv -----
// shared types, key codes and lookup tables for the keypad code lock
`timescale 1ns / 1ps

package kscl_pkg;

    // key codes
    localparam logic [4:0] KEY_NONE    = 5'd0;
    localparam logic [4:0] KEY_CLEAR   = 5'd15;
    localparam logic [4:0] KEY_CONFIRM = 5'd16;

    // event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_STORED   = 3'd1;
    localparam logic [2:0] EV_CLEARED  = 3'd2;
    localparam logic [2:0] EV_OVERFLOW = 3'd3;
    localparam logic [2:0] EV_CORRECT  = 3'd4;
    localparam logic [2:0] EV_WRONG    = 3'd5;

    // register indexes (word address bits 3..2)
    localparam logic [1:0] REG_LOCK_ENABLE    = 2'd0;
    localparam logic [1:0] REG_CODE_DIGITS    = 2'd1;
    localparam logic [1:0] REG_HOLD_THRESHOLD = 2'd2;

    // register reset values
    localparam logic        RST_LOCK_ENABLE    = 1'b1;
    localparam logic [23:0] RST_CODE_DIGITS    = 24'h200997;
    localparam logic [7:0]  RST_HOLD_THRESHOLD = 8'd5;

    localparam int CODE_NIBBLES = 6;
    localparam logic [3:0] BCD_MAX = 4'd9;

    typedef struct packed {
        logic [3:0] column_drive;
        logic [4:0] key_code;
        logic [2:0] event_res;
        logic [2:0] entered_count;
        logic       pass_right;
    } t_result;

    // row 0 is pin 4, column 0 is pin 0
    function automatic logic [4:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [4:0] key;
        unique case ({row, col})
            4'h0: key = 5'd14;
            4'h1: key = KEY_CONFIRM;
            4'h2: key = 5'd1;
            4'h3: key = KEY_CLEAR;
            4'h4: key = 5'd13;
            4'h5: key = 5'd10;
            4'h6: key = 5'd9;
            4'h7: key = 5'd8;
            4'h8: key = 5'd12;
            4'h9: key = 5'd7;
            4'hA: key = 5'd6;
            4'hB: key = 5'd5;
            4'hC: key = 5'd11;
            4'hD: key = 5'd4;
            4'hE: key = 5'd3;
            4'hF: key = 5'd2;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

    // index of the single set bit; valid flag false when not exactly one
    function automatic logic [2:0] one_hot4(input logic [3:0] v);
        logic [2:0] res;
        unique case (v)
            4'b0001: res = 3'b100;
            4'b0010: res = 3'b101;
            4'b0100: res = 3'b110;
            4'b1000: res = 3'b111;
            default: res = 3'b000;
        endcase
        return res;
    endfunction

endpackage

// ----- sv/keypad_scan_code_lock.sv -----
// keypad scanner with code lock: decode, hold qualifier, entry store and compare
`timescale 1ns / 1ps

// Usage: each request on the input channel (i_in_valid / o_in_stall) is either a
// column sweep tick (i_kind = 0) or a pin sample to decode (i_kind = 1). Every
// request yields exactly one result on the output channel (o_out_valid /
// i_out_stall): column levels, decoded key, event, entry count and right flag.
// A request is taken when valid is high and stall is low at a rising edge.
// The decode, hold counter, slot write and parallel compare of all code slots
// sit between the state registers and the result register, so one request per
// cycle is sustained while o_in_stall is low. A two-entry output stage (result
// register plus skid register) keeps accepting one more request while the
// receiver stalls; o_in_stall rises only once both entries hold results.
// Configuration goes through the APB port (lock enable at 0x0, code digits
// at 0x4, hold threshold at 0x8) and must be written only while the block is
// idle; the block does not enforce this. Synchronous active-low reset restores
// the default configuration, sets the sweep to the last column, clears the
// entry slots and counters, sets the right flag and empties the output stage.
module keypad_scan_code_lock
    import kscl_pkg::*;
#(
    parameter int CODE_LENGTH = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_pin_levels,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_column_drive,
    output logic [4:0]  o_key_code,
    output logic [2:0]  o_event_res,
    output logic [2:0]  o_entered_count,
    output logic        o_pass_right,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] CODE_LEN_W = 4'(CODE_LENGTH);
    localparam logic [2:0] COUNT_MAX  = 3'd7;

    // configuration registers
    logic        r_lock_enable;
    logic [23:0] r_code_digits;
    logic [7:0]  r_hold_threshold;

    // lock state
    logic [1:0]  r_sweep_phase, n_sweep_phase;
    logic [4:0]  r_last_key, n_last_key;
    logic [7:0]  r_hold_count, n_hold_count;
    logic [2:0]  r_entry_count, n_entry_count;
    logic [4:0]  r_slots [CODE_LENGTH];
    logic [4:0]  n_slots [CODE_LENGTH];
    logic        r_right_flag, n_right_flag;

    // output stage
    t_result     r_out, r_skid, n_result;
    logic        r_out_valid, r_skid_valid;

    logic        in_accept, out_accept, cfg_write;
    logic [2:0]  row_hot, col_hot;
    logic [4:0]  key;
    logic [7:0]  thr, hold_inc;
    logic        same_key, key_accept, code_match;
    logic [2:0]  count_inc;
    logic [2:0]  ev;

    function automatic logic [3:0] code_nibble(input logic [23:0] code, input int k);
        logic [3:0] nib;
        nib = 4'd0;
        if (k >= 0 && k < CODE_NIBBLES) begin
            nib = code[4*k +: 4];
        end
        return nib;
    endfunction

    assign in_accept  = i_in_valid & ~o_in_stall;
    assign out_accept = r_out_valid & ~i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign cfg_write  = psel & penable & pwrite & pready;
    assign pready     = 1'b1;

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            REG_LOCK_ENABLE:    prdata = {31'd0, r_lock_enable};
            REG_CODE_DIGITS:    prdata = {8'd0, r_code_digits};
            REG_HOLD_THRESHOLD: prdata = {24'd0, r_hold_threshold};
            default:            prdata = 32'd0;
        endcase
    end

    // key decode: both groups low active, exactly one low in each
    always_comb begin
        row_hot = one_hot4(~i_pin_levels[7:4]);
        col_hot = one_hot4(~i_pin_levels[3:0]);
        key = (row_hot[2] && col_hot[2]) ? key_lookup(row_hot[1:0], col_hot[1:0]) : KEY_NONE;
    end

    // hold qualifier
    always_comb begin
        thr      = (r_hold_threshold == 8'd0) ? 8'd1 : r_hold_threshold;
        same_key = (key != KEY_NONE) && (key == r_last_key);
        hold_inc = same_key ? ((r_hold_count == 8'hFF) ? 8'hFF : r_hold_count + 8'd1) : 8'd0;
        key_accept = i_kind && r_lock_enable && (hold_inc >= thr);
    end

    // compare all slots against the configured code
    always_comb begin
        count_inc  = (r_entry_count == COUNT_MAX) ? COUNT_MAX : r_entry_count + 3'd1;
        code_match = ({1'b0, count_inc} >= CODE_LEN_W);
        for (int i = 0; i < CODE_LENGTH; i++) begin
            if (code_nibble(r_code_digits, CODE_LENGTH - 1 - i) > BCD_MAX ||
                r_slots[i] != {1'b0, code_nibble(r_code_digits, CODE_LENGTH - 1 - i)} + 5'd1) begin
                code_match = 1'b0;
            end
        end
    end

    always_comb begin
        n_sweep_phase = r_sweep_phase;
        n_last_key    = r_last_key;
        n_hold_count  = r_hold_count;
        n_entry_count = r_entry_count;
        n_right_flag  = r_right_flag;
        ev            = EV_NONE;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            n_slots[i] = r_slots[i];
        end

        if (!i_kind) begin
            n_sweep_phase = r_sweep_phase + 2'd1;
        end else if (r_lock_enable) begin
            n_last_key   = key;
            n_hold_count = key_accept ? 8'd0 : hold_inc;
            if (key_accept) begin
                n_entry_count = count_inc;
                if (key == KEY_CONFIRM) begin
                    n_right_flag = code_match;
                    ev = code_match ? EV_CORRECT : EV_WRONG;
                end else if (key == KEY_CLEAR) begin
                    n_entry_count = 3'd0;
                    ev = EV_CLEARED;
                    for (int i = 0; i < CODE_LENGTH; i++) begin
                        n_slots[i] = KEY_NONE;
                    end
                end else if ({1'b0, r_entry_count} >= CODE_LEN_W) begin
                    ev = EV_OVERFLOW;
                end else begin
                    ev = EV_STORED;
                    for (int i = 0; i < CODE_LENGTH; i++) begin
                        if ({1'b0, r_entry_count} == 4'(i)) begin
                            n_slots[i] = key;
                        end
                    end
                end
            end
        end

        n_result.column_drive  = ~(4'b0001 << n_sweep_phase);
        n_result.key_code      = i_kind ? key : KEY_NONE;
        n_result.event_res     = ev;
        n_result.entered_count = n_entry_count;
        n_result.pass_right    = n_right_flag & r_lock_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_enable    <= RST_LOCK_ENABLE;
            r_code_digits    <= RST_CODE_DIGITS;
            r_hold_threshold <= RST_HOLD_THRESHOLD;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_LOCK_ENABLE:    r_lock_enable    <= pwdata[0];
                REG_CODE_DIGITS:    r_code_digits    <= pwdata[23:0];
                REG_HOLD_THRESHOLD: r_hold_threshold <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_phase <= 2'd3;
            r_last_key    <= KEY_NONE;
            r_hold_count  <= 8'd0;
            r_entry_count <= 3'd0;
            r_right_flag  <= 1'b1;
            for (int i = 0; i < CODE_LENGTH; i++) begin
                r_slots[i] <= KEY_NONE;
            end
        end else if (in_accept) begin
            r_sweep_phase <= n_sweep_phase;
            r_last_key    <= n_last_key;
            r_hold_count  <= n_hold_count;
            r_entry_count <= n_entry_count;
            r_right_flag  <= n_right_flag;
            for (int i = 0; i < CODE_LENGTH; i++) begin
                r_slots[i] <= n_slots[i];
            end
        end
    end

    // result register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_accept || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_accept || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_column_drive  = r_out.column_drive;
    assign o_key_code      = r_out.key_code;
    assign o_event_res     = r_out.event_res;
    assign o_entered_count = r_out.entered_count;
    assign o_pass_right    = r_out.pass_right;

endmodule
